>>> rtl/core/gwm_pkg.sv
// Shared constants and types of the glob wildcard matcher.
package gwm_pkg;

	localparam int PATTERN_MAX_DEF = 64;

	localparam logic [7:0] STAR_BYTE     = 8'h2A;
	localparam logic [7:0] QUESTION_BYTE = 8'h3F;

	typedef logic [1:0] func_t;

	localparam func_t FUNC_CLEAR   = 2'd0;
	localparam func_t FUNC_APPEND  = 2'd1;
	localparam func_t FUNC_SUBJECT = 2'd2;
	localparam func_t FUNC_END     = 2'd3;

	typedef struct packed {
		logic       clear;
		logic       append;
		logic       consume;
		logic       restart;
		logic [7:0] data;
	} req_t;

endpackage

>>> rtl/core/glob_wildcard_match.sv
// Glob matcher top level: row of pattern cells, star closure and result register.
// An end-of-subject request gives its registered result in the cycle after acceptance.
// Throughput: one request per cycle while no stalled result is held; each subject byte updates every cell at once.
// The star closure is a log-depth scan across the pattern positions.
// Reset clears the pattern, overflow flag and result; position zero starts active.
// No clearing pass: pattern bytes are read only after they have been written.
module glob_wildcard_match #(
	parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  gwm_pkg::func_t func,
	input  logic [7:0]     data_byte,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           matched,
	output logic           pattern_overflow
);
	import gwm_pkg::*;

	localparam int NPOS = PATTERN_MAX + 1;

	req_t                   req;
	logic                   in_acc;
	logic [PATTERN_MAX-1:0] loaded;
	logic [PATTERN_MAX-1:0] star;
	logic [PATTERN_MAX-1:0] adv;
	logic [NPOS-1:0]        raw;
	logic [NPOS-1:0]        prop;
	logic [NPOS-1:0]        cl;
	logic [NPOS-1:0]        tail;
	logic                   raw_last_q;
	logic                   ovf_q;
	logic                   out_valid_q;
	logic                   matched_q;
	logic                   ovf_out_q;
	logic                   hit;

	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	assign req.clear   = in_acc && (func == FUNC_CLEAR);
	assign req.append  = in_acc && (func == FUNC_APPEND);
	assign req.consume = in_acc && (func == FUNC_SUBJECT);
	assign req.restart = in_acc && (func != FUNC_SUBJECT);
	assign req.data    = data_byte;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		gwm_cell #(
			.FIRST(i == 0)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.req        (req),
			.prev_loaded((i == 0) ? 1'b1 : loaded[(i == 0) ? 0 : i-1]),
			.adv_in     ((i == 0) ? 1'b0 : adv[(i == 0) ? 0 : i-1]),
			.cl_in      (cl[i]),
			.loaded     (loaded[i]),
			.star       (star[i]),
			.raw        (raw[i]),
			.adv_out    (adv[i])
		);
	end

	assign raw[PATTERN_MAX] = raw_last_q;
	assign prop             = {star, 1'b0};

	gwm_star_scan #(
		.NPOS(NPOS)
	) u_scan (
		.raw (raw),
		.prop(prop),
		.cl  (cl)
	);

	assign tail[0]           = !loaded[0];
	assign tail[PATTERN_MAX] = loaded[PATTERN_MAX-1];
	for (genvar j = 1; j < PATTERN_MAX; j++) begin : g_tail
		assign tail[j] = loaded[j-1] && !loaded[j];
	end

	assign hit = |(cl & tail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_last_q  <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			matched_q   <= 1'b0;
			ovf_out_q   <= 1'b0;
		end else begin
			if (req.consume) begin
				raw_last_q <= adv[PATTERN_MAX-1];
			end else if (req.restart) begin
				raw_last_q <= 1'b0;
			end
			if (req.clear) begin
				ovf_q <= 1'b0;
			end else if (req.append && loaded[PATTERN_MAX-1]) begin
				ovf_q <= 1'b1;
			end
			if (in_acc && (func == FUNC_END)) begin
				out_valid_q <= 1'b1;
				matched_q   <= hit && !ovf_q;
				ovf_out_q   <= ovf_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = ovf_out_q;

	a_loaded_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((loaded >> 1) & ~loaded) == '0)
		else $error("pattern cells loaded out of order");

	a_overflow_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pattern_overflow |-> !matched)
		else $error("match reported with overflowed pattern");

	a_clear_drops_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		req.clear |=> !ovf_q && (loaded == '0))
		else $error("clear did not empty the pattern");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (func == FUNC_END) |=> out_valid)
		else $error("end of subject produced no result");

endmodule

>>> rtl/core/gwm_cell.sv
// One pattern cell: stored byte, load flag and raw activity of its position.
module gwm_cell #(
	parameter bit FIRST = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  gwm_pkg::req_t req,
	input  logic          prev_loaded,
	input  logic          adv_in,
	input  logic          cl_in,
	output logic          loaded,
	output logic          star,
	output logic          raw,
	output logic          adv_out
);
	import gwm_pkg::*;

	logic [7:0] pat_q;
	logic       loaded_q;
	logic       raw_q;
	logic       stay;
	logic       hit;

	assign star    = loaded_q && (pat_q == STAR_BYTE);
	assign hit     = (pat_q == req.data) || (pat_q == QUESTION_BYTE);
	assign stay    = cl_in && star;
	assign adv_out = cl_in && loaded_q && !star && hit;
	assign loaded  = loaded_q;
	assign raw     = raw_q;

	always_ff @(posedge clk) begin
		if (req.append && prev_loaded && !loaded_q) begin
			pat_q <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			raw_q    <= FIRST;
		end else begin
			if (req.clear) begin
				loaded_q <= 1'b0;
			end else if (req.append && prev_loaded) begin
				loaded_q <= 1'b1;
			end
			if (req.consume) begin
				raw_q <= stay || adv_in;
			end else if (req.restart) begin
				raw_q <= FIRST;
			end
		end
	end

endmodule

>>> rtl/core/gwm_star_scan.sv
// Segmented prefix scan that closes activity over runs of stars.
module gwm_star_scan #(
	parameter int NPOS = gwm_pkg::PATTERN_MAX_DEF + 1
) (
	input  logic [NPOS-1:0] raw,
	input  logic [NPOS-1:0] prop,
	output logic [NPOS-1:0] cl
);
	localparam int LEVELS = (NPOS > 1) ? $clog2(NPOS) : 1;

	logic [NPOS-1:0] g_lv [LEVELS+1];
	logic [NPOS-1:0] p_lv [LEVELS+1];

	assign g_lv[0] = raw;
	assign p_lv[0] = prop;

	for (genvar lv = 0; lv < LEVELS; lv++) begin : g_level
		localparam int DIST = 1 << lv;
		always_comb begin
			g_lv[lv+1] = g_lv[lv];
			p_lv[lv+1] = p_lv[lv];
			for (int j = DIST; j < NPOS; j++) begin
				g_lv[lv+1][j] = g_lv[lv][j] | (p_lv[lv][j] & g_lv[lv][j-DIST]);
				p_lv[lv+1][j] = p_lv[lv][j] & p_lv[lv][j-DIST];
			end
		end
	end

	assign cl = g_lv[LEVELS];

endmodule

>>> dv/glob_match_checker.sv
// Checker for the glob matcher: predicts each end-of-subject verdict and compares results.
`timescale 1ns / 1ps

module glob_match_checker #(
	parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  gwm_pkg::func_t func,
	input  logic [7:0]     data_byte,
	input  logic           out_valid,
	input  logic           out_stall,
	input  logic           matched,
	input  logic           pattern_overflow,
	output int             mismatches,
	output int             verdicts_pending
);
	import gwm_pkg::*;

	typedef struct packed {
		logic hit;
		logic ovf;
	} verdict_t;

	logic [7:0]         pat_bytes [PATTERN_MAX];
	int                 pat_len;
	logic [PATTERN_MAX:0] live;
	logic               ovf_flag;
	verdict_t           verdicts_due [$];
	int                 results_seen;

	// star positions pass activity on, since a star may match nothing
	function automatic logic [PATTERN_MAX:0] star_closure(input logic [PATTERN_MAX:0] s);
		for (int i = 0; i < pat_len; i++) begin
			if (s[i] && pat_bytes[i] == STAR_BYTE)
				s[i + 1] = 1'b1;
		end
		return s;
	endfunction

	function automatic logic [PATTERN_MAX:0] fresh_subject();
		logic [PATTERN_MAX:0] s;
		s = '0;
		s[0] = 1'b1;
		return star_closure(s);
	endfunction

	function automatic logic [PATTERN_MAX:0] advance_automaton(input logic [7:0] ch);
		logic [PATTERN_MAX:0] nxt;
		nxt = '0;
		for (int i = 0; i < pat_len; i++) begin
			if (live[i]) begin
				if (pat_bytes[i] == STAR_BYTE)
					nxt[i] = 1'b1;
				else if (pat_bytes[i] == ch || pat_bytes[i] == QUESTION_BYTE)
					nxt[i + 1] = 1'b1;
			end
		end
		return star_closure(nxt);
	endfunction

	task automatic predict_request(input func_t f, input logic [7:0] b);
		verdict_t v;
		case (f)
			FUNC_CLEAR: begin
				pat_len  = 0;
				ovf_flag = 1'b0;
				live     = fresh_subject();
			end
			FUNC_APPEND: begin
				if (pat_len < PATTERN_MAX) begin
					pat_bytes[pat_len] = b;
					pat_len++;
				end else begin
					ovf_flag = 1'b1;
				end
				live = fresh_subject();
			end
			FUNC_SUBJECT: begin
				live = advance_automaton(b);
			end
			default: begin
				v.hit = live[pat_len] && !ovf_flag;
				v.ovf = ovf_flag;
				verdicts_due.push_back(v);
				live = fresh_subject();
			end
		endcase
	endtask

	task automatic flag_result(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: result %0d: %s", $time, results_seen, msg);
	endtask

	task automatic check_result();
		verdict_t want;
		if (verdicts_due.size() == 0) begin
			flag_result($sformatf("unexpected, matched=%0b overflow=%0b",
				matched, pattern_overflow));
		end else begin
			want = verdicts_due.pop_front();
			if (want.hit !== matched || want.ovf !== pattern_overflow)
				flag_result($sformatf("expected matched=%0b overflow=%0b, got matched=%0b overflow=%0b",
					want.hit, want.ovf, matched, pattern_overflow));
		end
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len          = 0;
			ovf_flag         = 1'b0;
			live             = fresh_subject();
			verdicts_due.delete();
			mismatches       = 0;
			results_seen     = 0;
			verdicts_pending = 0;
		end else begin
			if (in_valid && !in_stall)
				predict_request(func, data_byte);
			if (out_valid && !out_stall)
				check_result();
			verdicts_pending = verdicts_due.size();
		end
	end

endmodule

>>> dv/tb_top.sv
// Testbench top for the glob matcher: clock, reset, request stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
	import gwm_pkg::*;

	localparam int PATTERN_MAX     = PATTERN_MAX_DEF;
	localparam int ITEMS_PER_PHASE = 350;
	localparam int HOLD_CYCLES     = 80;
	localparam int QUIET_LIMIT     = 4000;
	localparam int TAIL_CYCLES     = 10;

	localparam logic [7:0] CHAR_A = 8'h61;
	localparam logic [7:0] CHAR_B = 8'h62;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	func_t      func;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_stall;
	logic       matched;
	logic       pattern_overflow;

	int         mismatches;
	int         verdicts_pending;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	logic       hold_rq = 1'b0;
	int         items_sent = 0;
	int         quiet_cycles = 0;
	logic [7:0] pat_q [$];

	glob_wildcard_match #(.PATTERN_MAX(PATTERN_MAX)) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.data_byte        (data_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.matched          (matched),
		.pattern_overflow (pattern_overflow)
	);

	glob_match_checker #(.PATTERN_MAX(PATTERN_MAX)) u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.data_byte        (data_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.matched          (matched),
		.pattern_overflow (pattern_overflow),
		.mismatches       (mismatches),
		.verdicts_pending (verdicts_pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: random stalls, or a long hold when asked
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rq) begin
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_req(input func_t f, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		func      <= f;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (f == FUNC_CLEAR)
			pat_q.delete();
		else if (f == FUNC_APPEND && pat_q.size() < PATTERN_MAX)
			pat_q.push_back(b);
		@(negedge clk);
	endtask

	task automatic pause_cycle();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (verdicts_pending != 0)
			pause_cycle();
	endtask

	function automatic logic [7:0] pick_pattern_char();
		case ($urandom_range(9))
			0, 1, 2: return CHAR_A;
			3, 4:    return CHAR_B;
			5, 6:    return STAR_BYTE;
			7:       return QUESTION_BYTE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] subject_char();
		if ($urandom_range(3) == 0)
			return 8'($urandom_range(255));
		return $urandom_range(1) ? CHAR_A : CHAR_B;
	endfunction

	// build a subject that follows the pattern, sometimes bent so it may fail
	task automatic run_subject();
		logic mutate;
		mutate = ($urandom_range(3) == 0);
		foreach (pat_q[i]) begin
			if (mutate && $urandom_range(4) == 0) begin
				if ($urandom_range(1))
					send_req(FUNC_SUBJECT, subject_char());
				continue;
			end
			if (pat_q[i] == STAR_BYTE)
				repeat ($urandom_range(3)) send_req(FUNC_SUBJECT, subject_char());
			else if (pat_q[i] == QUESTION_BYTE)
				send_req(FUNC_SUBJECT, 8'($urandom_range(255)));
			else
				send_req(FUNC_SUBJECT, pat_q[i]);
		end
		if (mutate && $urandom_range(1))
			send_req(FUNC_SUBJECT, subject_char());
		send_req(FUNC_END, 8'($urandom_range(255)));
	endtask

	task automatic random_scenario(input bit force_long);
		int len;
		int r;
		r = $urandom_range(99);
		if (!force_long && r < 8) begin
			repeat ($urandom_range(1, 6))
				send_req(func_t'($urandom_range(3)), 8'($urandom_range(255)));
			return;
		end
		if (force_long || r < 12)
			len = $urandom_range(PATTERN_MAX - 2, PATTERN_MAX + 3);
		else
			len = $urandom_range(0, 8);
		if (force_long || $urandom_range(4) != 0)
			send_req(FUNC_CLEAR, 8'($urandom_range(255)));
		repeat (len)
			send_req(FUNC_APPEND, pick_pattern_char());
		repeat ($urandom_range(1, (len > 16) ? 2 : 5))
			run_subject();
	endtask

	// hold the receiver off while a result waits and requests stall behind it
	task automatic long_hold_burst();
		hold_rq <= 1'b1;
		pause_cycle();
		hold_rq <= 1'b0;
		send_req(FUNC_CLEAR, 8'h00);
		send_req(FUNC_APPEND, STAR_BYTE);
		repeat (20) begin
			send_req(FUNC_SUBJECT, 8'($urandom_range(255)));
			send_req(FUNC_END, 8'($urandom_range(255)));
		end
	endtask

	task automatic directed_requests();
		send_req(FUNC_END, 8'h00);
		send_req(FUNC_SUBJECT, 8'h00);
		send_req(FUNC_END, 8'hFF);
		send_req(FUNC_APPEND, STAR_BYTE);
		send_req(FUNC_END, 8'h00);
		send_req(FUNC_SUBJECT, 8'hFF);
		send_req(FUNC_END, 8'h00);
		send_req(FUNC_CLEAR, 8'hFF);
		send_req(FUNC_APPEND, CHAR_A);
		send_req(FUNC_APPEND, QUESTION_BYTE);
		send_req(FUNC_APPEND, STAR_BYTE);
		send_req(FUNC_APPEND, 8'h00);
		send_req(FUNC_APPEND, 8'hFF);
		send_req(FUNC_SUBJECT, CHAR_A);
		send_req(FUNC_SUBJECT, STAR_BYTE);
		send_req(FUNC_SUBJECT, 8'h00);
		send_req(FUNC_SUBJECT, 8'h55);
		send_req(FUNC_SUBJECT, 8'h00);
		send_req(FUNC_SUBJECT, 8'hFF);
		send_req(FUNC_END, 8'h00);
		send_req(FUNC_SUBJECT, CHAR_B);
		send_req(FUNC_APPEND, QUESTION_BYTE);
		send_req(FUNC_SUBJECT, CHAR_A);
		send_req(FUNC_END, 8'hAA);
		send_req(FUNC_CLEAR, 8'h00);
		send_req(FUNC_END, 8'h00);
	endtask

	initial begin
		int target;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		func      = FUNC_CLEAR;
		data_byte = 8'h00;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_requests();
		random_scenario(1'b1);
		send_req(FUNC_END, 8'h00);
		send_req(FUNC_CLEAR, 8'h00);
		send_req(FUNC_END, 8'h00);

		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 36 : (p == 1) ? 71 : 0;
			recv_idle_pct = (p == 0) ? 71 : (p == 1) ? 36 : 0;
			if (p == 2)
				long_hold_burst();
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target)
				random_scenario(1'b0);
			pause_cycle();
			wait_drained();
		end

		repeat (TAIL_CYCLES) pause_cycle();
		if (mismatches == 0 && verdicts_pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
